[rtl/dsls_pkg.sv]
package dsls_pkg;

    localparam int unsigned LedCount    = 6;
    localparam int unsigned DigitWidth  = 4;
    localparam int unsigned StrokeWidth = 3;
    localparam int unsigned TickWidth   = 16;

    localparam logic [DigitWidth-1:0]  DigitMax   = 4'd9;
    localparam logic [DigitWidth-1:0]  DigitTen   = 4'd10;
    localparam logic [StrokeWidth-1:0] StrokeAll  = 3'd6;
    localparam logic [LedCount-1:0]    MaskAll    = 6'h3F;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [15:0] RecipTen   = 16'd52429;
    localparam int unsigned RecipShift = 19;

    localparam logic [TickWidth-1:0] StepTicksReset = 16'd960;
    localparam logic [TickWidth-1:0] GapTicksReset  = 16'd1920;

    typedef enum logic [0:0] {
        CFG_STEP_TICKS = 1'b0,
        CFG_GAP_TICKS  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [TickWidth-1:0] step_ticks;
        logic [TickWidth-1:0] gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [LedCount-1:0] led_mask;
        logic                busy;
    } result_t;

    function automatic logic [StrokeWidth-1:0] stroke_len(input logic [DigitWidth-1:0] d);
        logic [StrokeWidth-1:0] len;
        unique case (d)
            4'd0:    len = 3'd1;
            4'd1:    len = 3'd3;
            4'd2:    len = 3'd6;
            4'd3:    len = 3'd6;
            4'd4:    len = 3'd5;
            4'd5:    len = 3'd6;
            4'd6:    len = 3'd6;
            4'd7:    len = 3'd4;
            4'd8:    len = 3'd7;
            4'd9:    len = 3'd5;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [StrokeWidth-1:0] stroke_code(
        input logic [DigitWidth-1:0]  d,
        input logic [StrokeWidth-1:0] p
    );
        logic [StrokeWidth*7-1:0] row;
        unique case (d)
            4'd0:    row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd6};
            4'd1:    row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd3, 3'd1};
            4'd2:    row = {3'd0, 3'd5, 3'd4, 3'd2, 3'd3, 3'd1, 3'd0};
            4'd3:    row = {3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd1, 3'd0};
            4'd4:    row = {3'd0, 3'd0, 3'd5, 3'd1, 3'd3, 3'd2, 3'd0};
            4'd5:    row = {3'd0, 3'd4, 3'd5, 3'd3, 3'd2, 3'd0, 3'd1};
            4'd6:    row = {3'd0, 3'd3, 3'd5, 3'd4, 3'd2, 3'd0, 3'd1};
            4'd7:    row = {3'd0, 3'd0, 3'd0, 3'd5, 3'd3, 3'd1, 3'd0};
            4'd8:    row = {3'd2, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0, 3'd3};
            4'd9:    row = {3'd0, 3'd0, 3'd5, 3'd1, 3'd0, 3'd3, 3'd4};
            default: row = '0;
        endcase
        if (p == 3'd7)
        begin
            return 3'd0;
        end
        return row[p*StrokeWidth +: StrokeWidth];
    endfunction

    function automatic logic [LedCount-1:0] stroke_mask(
        input logic [DigitWidth-1:0]  d,
        input logic [StrokeWidth-1:0] p
    );
        logic [StrokeWidth-1:0] code;
        code = stroke_code(d, p);
        if (code == StrokeAll)
        begin
            return MaskAll;
        end
        if (code < StrokeAll)
        begin
            return LedCount'(1) << code;
        end
        return '0;
    endfunction

endpackage

[rtl/dsls_core.sv]
module dsls_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        func,
    input  logic signed [15:0]          number,
    input  dsls_pkg::cfg_t              cfg,
    output dsls_pkg::result_t           result
);

    localparam int unsigned DW = dsls_pkg::DigitWidth;
    localparam int unsigned SW = dsls_pkg::StrokeWidth;
    localparam int unsigned TW = dsls_pkg::TickWidth;
    localparam int unsigned LW = dsls_pkg::LedCount;

    logic          running_reg,   running_next;
    logic          drawing_reg,   drawing_next;
    logic [DW-1:0] digit_reg,     digit_next;
    logic [SW-1:0] stroke_reg,    stroke_next;
    logic [TW-1:0] step_cnt_reg,  step_cnt_next;
    logic [TW-1:0] gap_cnt_reg,   gap_cnt_next;
    logic [DW-1:0] queue0_reg,    queue0_next;
    logic [DW-1:0] queue1_reg,    queue1_next;
    logic [1:0]    dcount_reg,    dcount_next;
    logic [1:0]    dpos_reg,      dpos_next;
    logic [LW-1:0] mask_reg,      mask_next;

    // split the start number into digits
    logic [14:0]   value;
    logic [30:0]   product;
    logic [11:0]   quot;
    logic [14:0]   rem_full;
    logic [DW-1:0] tens;
    logic [DW-1:0] ones;
    logic          two_digits;
    logic [DW-1:0] first_digit;
    logic [DW-1:0] gap_digit;
    logic [SW-1:0] stroke_inc;

    assign value      = number[15] ? '0 : number[14:0];
    assign product    = 31'(value) * 31'(dsls_pkg::RecipTen);
    assign quot       = product[30:dsls_pkg::RecipShift];
    assign rem_full   = value - (15'(quot) << 3) - (15'(quot) << 1);
    assign ones       = rem_full[DW-1:0];
    assign tens       = (quot > 12'(dsls_pkg::DigitMax)) ? dsls_pkg::DigitMax : quot[DW-1:0];
    assign two_digits = value >= 15'(dsls_pkg::DigitTen);
    assign first_digit = two_digits ? tens : ones;
    assign gap_digit  = dpos_reg[0] ? queue1_reg : queue0_reg;
    assign stroke_inc = stroke_reg + SW'(1);

    always_comb
    begin
        running_next  = running_reg;
        drawing_next  = drawing_reg;
        digit_next    = digit_reg;
        stroke_next   = stroke_reg;
        step_cnt_next = step_cnt_reg;
        gap_cnt_next  = gap_cnt_reg;
        queue0_next   = queue0_reg;
        queue1_next   = queue1_reg;
        dcount_next   = dcount_reg;
        dpos_next     = dpos_reg;
        mask_next     = mask_reg;
        if (func)
        begin
            // start drops whatever was running
            queue0_next   = first_digit;
            if (two_digits)
            begin
                queue1_next = ones;
            end
            dcount_next   = two_digits ? 2'd2 : 2'd1;
            dpos_next     = '0;
            digit_next    = first_digit;
            stroke_next   = '0;
            step_cnt_next = cfg.step_ticks;
            gap_cnt_next  = '0;
            running_next  = 1'b1;
            drawing_next  = 1'b1;
            mask_next     = dsls_pkg::stroke_mask(first_digit, '0);
        end
        else if (running_reg)
        begin
            priority if (gap_cnt_reg != '0)
            begin
                mask_next    = '0;
                gap_cnt_next = gap_cnt_reg - TW'(1);
                if (gap_cnt_reg == TW'(1) && dpos_reg < dcount_reg)
                begin
                    digit_next    = gap_digit;
                    stroke_next   = '0;
                    step_cnt_next = cfg.step_ticks;
                    running_next  = 1'b1;
                    drawing_next  = 1'b1;
                    mask_next     = dsls_pkg::stroke_mask(gap_digit, '0);
                end
            end
            else if (!drawing_reg)
            begin
                running_next = 1'b0;
                mask_next    = '0;
            end
            else if (step_cnt_reg > TW'(1))
            begin
                step_cnt_next = step_cnt_reg - TW'(1);
            end
            else if (stroke_inc >= dsls_pkg::stroke_len(digit_reg))
            begin
                // digit finished: gap before the next one, or stop
                stroke_next  = stroke_inc;
                dpos_next    = dpos_reg + 2'd1;
                drawing_next = 1'b0;
                mask_next    = '0;
                if (dpos_reg + 2'd1 < dcount_reg)
                begin
                    gap_cnt_next = cfg.gap_ticks;
                end
                else
                begin
                    running_next = 1'b0;
                    dcount_next  = '0;
                end
            end
            else
            begin
                stroke_next   = stroke_inc;
                step_cnt_next = cfg.step_ticks;
                mask_next     = dsls_pkg::stroke_mask(digit_reg, stroke_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            drawing_reg  <= 1'b0;
            digit_reg    <= '0;
            stroke_reg   <= '0;
            step_cnt_reg <= '0;
            gap_cnt_reg  <= '0;
            queue0_reg   <= '0;
            queue1_reg   <= '0;
            dcount_reg   <= '0;
            dpos_reg     <= '0;
            mask_reg     <= '0;
        end
        else if (take)
        begin
            running_reg  <= running_next;
            drawing_reg  <= drawing_next;
            digit_reg    <= digit_next;
            stroke_reg   <= stroke_next;
            step_cnt_reg <= step_cnt_next;
            gap_cnt_reg  <= gap_cnt_next;
            queue0_reg   <= queue0_next;
            queue1_reg   <= queue1_next;
            dcount_reg   <= dcount_next;
            dpos_reg     <= dpos_next;
            mask_reg     <= mask_next;
        end
    end

    assign result.led_mask = mask_next;
    assign result.busy     = running_next;

endmodule

[rtl/dsls_outq.sv]
module dsls_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dsls_pkg::result_t  push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output dsls_pkg::result_t  out_data
);

    dsls_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign out_valid = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;
    assign pop       = out_valid && !out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/digit_stroke_led_sequencer_top.sv]
// Channel   Signals                          Direction  Transfer when
// input     in_valid, in_stall, func, number in         in_valid && !in_stall
// output    out_valid, out_stall, led_mask,  out        out_valid && !out_stall
//           busy_res
// config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// One item per cycle while in_stall is low; each result is queued when taken.
// The sequencer state updates in the same cycle the item is taken.
// A two-entry result queue holds results while the output is stalled;
// in_stall rises only when both entries are occupied.
// Reset clears the sequencer state and the queue; step_ticks returns to 960
// and gap_ticks to 1920.
module digit_stroke_led_sequencer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [15:0] number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         led_mask,
    output logic               busy_res,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    dsls_pkg::cfg_t    cfg_reg;
    dsls_pkg::result_t core_result;
    dsls_pkg::result_t queue_head;
    logic              take;
    logic              queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ticks <= dsls_pkg::StepTicksReset;
            cfg_reg.gap_ticks  <= dsls_pkg::GapTicksReset;
        end
        else if (cfg_we)
        begin
            unique case (dsls_pkg::cfg_index_t'(cfg_index))
                dsls_pkg::CFG_STEP_TICKS: cfg_reg.step_ticks <= cfg_data;
                dsls_pkg::CFG_GAP_TICKS:  cfg_reg.gap_ticks  <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign in_stall = queue_full;
    assign take     = in_valid && !queue_full;

    dsls_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .func   (func),
        .number (number),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    dsls_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (core_result),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (queue_head)
    );

    assign led_mask = queue_head.led_mask;
    assign busy_res = queue_head.busy;

endmodule
